@@ rtl/sst_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted set table package
// Shared types, action and cell codes, and defaults for the sorted set table.
// ----------------------------------------------------------------------------
`default_nettype none

package sst_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int VAL_W     = 32;
  localparam int SIZE_W    = 7;

  typedef enum logic [2:0] {
    ACT_CLEAR  = 3'd0,
    ACT_LOOKUP = 3'd1,
    ACT_INSERT = 3'd2,
    ACT_REMOVE = 3'd3,
    ACT_MATCH  = 3'd4,
    ACT_KEEP   = 3'd5
  } act_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_CLR,
    CELL_INS,
    CELL_REM,
    CELL_MARK,
    CELL_COMPACT
  } cell_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_COMPACT
  } state_e;

  typedef struct packed {
    logic [2:0]              action;
    logic signed [VAL_W-1:0] value;
    logic                    final_req;
  } in_item_t;

  typedef struct packed {
    logic              hit;
    logic              dropped;
    logic [SIZE_W-1:0] size;
    logic              subset;
    logic              equal;
  } out_item_t;

  typedef struct packed {
    cell_op_e                op;
    logic                    probe;
    logic signed [VAL_W-1:0] value;
  } cell_cmd_t;

endpackage

`default_nettype wire

@@ rtl/sst_cell.sv @@
// ----------------------------------------------------------------------------
// Sorted set table cell
// One table slot: holds a member and its match mark, compares it with the
// broadcast value and shifts with its neighbours on insert, remove and compact.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 7
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire sst_pkg::cell_cmd_t             cmd,
  input  wire [CNT_W-1:0]                     count,
  input  wire                                 lt_in,
  input  wire signed [sst_pkg::VAL_W-1:0]     val_left,
  input  wire signed [sst_pkg::VAL_W-1:0]     val_right,
  input  wire                                 mark_right,
  input  wire                                 hit_in,
  input  wire                                 unm_in,
  output logic                                lt_out,
  output logic signed [sst_pkg::VAL_W-1:0]    val_out,
  output logic                                mark_out,
  output logic                                hit_out,
  output logic                                unm_out
);

  logic signed [sst_pkg::VAL_W-1:0] value_r;
  logic signed [sst_pkg::VAL_W-1:0] value_nxt;
  logic                             mark_r;
  logic                             mark_nxt;
  logic                             occ;
  logic                             eq;
  logic                             mark_eff;

  always_comb begin
    occ      = CNT_W'(INDEX) < count;
    lt_out   = occ && (value_r < cmd.value);
    eq       = occ && (value_r == cmd.value);
    mark_eff = mark_r | (cmd.probe & eq);
    hit_out  = hit_in | eq;
    unm_out  = unm_in | (occ & ~mark_eff);
    val_out  = value_r;
    mark_out = mark_r;
  end

  always_comb begin
    value_nxt = value_r;
    mark_nxt  = mark_r;
    case (cmd.op)
      sst_pkg::CELL_HOLD: begin
      end
      sst_pkg::CELL_CLR: begin
        mark_nxt = 1'b0;
      end
      sst_pkg::CELL_INS: begin
        mark_nxt = 1'b0;
        if (!lt_out) begin
          value_nxt = lt_in ? cmd.value : val_left;
        end
      end
      sst_pkg::CELL_REM: begin
        mark_nxt = 1'b0;
        if (!lt_out) begin
          value_nxt = val_right;
        end
      end
      sst_pkg::CELL_MARK: begin
        mark_nxt = mark_eff;
      end
      sst_pkg::CELL_COMPACT: begin
        if (unm_out) begin
          value_nxt = val_right;
          mark_nxt  = mark_right;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    if (!rst_n) begin
      mark_r <= 1'b0;
    end else begin
      mark_r <= mark_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/sorted_set_table_top.sv @@
// ----------------------------------------------------------------------------
// Sorted set table
// Sorted set of unique signed 32-bit members held in a row of cells, with
// lookup, insert, remove, clear and streamed match / keep of another set.
//
//   channel  ports                    transfer
//   input    start, busy, in_item     start high and busy low at clk edge
//   result   out_valid, out_item      out_valid high, one cycle, no stall
//
// Each transfer but the one below gives one result on the cycle after it;
// busy stays low, so items can follow back to back. A final keep item that
// leaves unmatched members raises busy while they are deleted, one member per
// cycle, then marks are cleared; the result comes out as busy falls.
// Reset (synchronous) empties the table, clears marks and stream count.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_set_table_top #(
  parameter int DEPTH = sst_pkg::DEPTH_DEF
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     start,
  output logic                    busy,
  input  wire sst_pkg::in_item_t  in_item,
  output logic                    out_valid,
  output sst_pkg::out_item_t      out_item
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int TAL_W = $clog2(DEPTH + 2);

  sst_pkg::state_e    state_r;
  sst_pkg::state_e    state_nxt;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic [TAL_W-1:0]   tally_r;
  logic [TAL_W-1:0]   tally_nxt;
  logic [TAL_W-1:0]   tally_sat;
  logic               hit_pend_r;
  logic               hit_pend_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  sst_pkg::out_item_t out_item_r;
  sst_pkg::out_item_t out_item_nxt;
  sst_pkg::cell_cmd_t cmd;
  logic               accept;
  logic               hit;
  logic               any_unm;
  logic               full;
  logic               sub;
  logic               go_compact;

  logic                             lt_w   [DEPTH];
  logic signed [sst_pkg::VAL_W-1:0] val_w  [DEPTH];
  logic                             mark_w [DEPTH];
  logic                             hit_w  [DEPTH];
  logic                             unm_w  [DEPTH];

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic                             lt_l;
      logic signed [sst_pkg::VAL_W-1:0] val_l;
      logic signed [sst_pkg::VAL_W-1:0] val_rt;
      logic                             mark_rt;
      logic                             hit_l;
      logic                             unm_l;

      if (gi == 0) begin : g_first
        assign lt_l  = 1'b1;
        assign val_l = cmd.value;
        assign hit_l = 1'b0;
        assign unm_l = 1'b0;
      end else begin : g_mid
        assign lt_l  = lt_w[gi-1];
        assign val_l = val_w[gi-1];
        assign hit_l = hit_w[gi-1];
        assign unm_l = unm_w[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_last
        assign val_rt  = val_w[gi];
        assign mark_rt = 1'b0;
      end else begin : g_inner
        assign val_rt  = val_w[gi+1];
        assign mark_rt = mark_w[gi+1];
      end

      sst_cell #(
        .INDEX (gi),
        .CNT_W (CNT_W)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .count      (count_r),
        .lt_in      (lt_l),
        .val_left   (val_l),
        .val_right  (val_rt),
        .mark_right (mark_rt),
        .hit_in     (hit_l),
        .unm_in     (unm_l),
        .lt_out     (lt_w[gi]),
        .val_out    (val_w[gi]),
        .mark_out   (mark_w[gi]),
        .hit_out    (hit_w[gi]),
        .unm_out    (unm_w[gi])
      );
    end
  endgenerate

  assign hit     = hit_w[DEPTH-1];
  assign any_unm = unm_w[DEPTH-1];
  assign busy    = (state_r == sst_pkg::ST_COMPACT);
  assign accept  = start && !busy;
  assign full    = (count_r == CNT_W'(DEPTH));
  assign sub     = !any_unm;

  always_comb begin
    if (tally_r == TAL_W'(DEPTH + 1)) begin
      tally_sat = tally_r;
    end else begin
      tally_sat = tally_r + TAL_W'(1);
    end
    go_compact = accept && in_item.final_req && !sub &&
                 (in_item.action == sst_pkg::ACT_KEEP);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sst_pkg::ST_IDLE: begin
        if (go_compact) begin
          state_nxt = sst_pkg::ST_COMPACT;
        end
      end
      sst_pkg::ST_COMPACT: begin
        if (!any_unm) begin
          state_nxt = sst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sst_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.op        = sst_pkg::CELL_HOLD;
    cmd.probe     = 1'b0;
    cmd.value     = in_item.value;
    count_nxt     = count_r;
    tally_nxt     = tally_r;
    hit_pend_nxt  = hit_pend_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    case (state_r)
      sst_pkg::ST_IDLE: begin
        if (accept) begin
          out_valid_nxt        = 1'b1;
          out_item_nxt.hit     = hit;
          out_item_nxt.dropped = 1'b0;
          out_item_nxt.subset  = 1'b0;
          out_item_nxt.equal   = 1'b0;
          case (in_item.action)
            sst_pkg::ACT_CLEAR: begin
              cmd.op    = sst_pkg::CELL_CLR;
              count_nxt = '0;
              tally_nxt = '0;
            end
            sst_pkg::ACT_LOOKUP: begin
              cmd.op    = sst_pkg::CELL_CLR;
              tally_nxt = '0;
            end
            sst_pkg::ACT_INSERT: begin
              tally_nxt = '0;
              if (!hit && !full) begin
                cmd.op    = sst_pkg::CELL_INS;
                count_nxt = count_r + CNT_W'(1);
              end else begin
                cmd.op               = sst_pkg::CELL_CLR;
                out_item_nxt.dropped = !hit;
              end
            end
            sst_pkg::ACT_REMOVE: begin
              tally_nxt = '0;
              if (hit) begin
                cmd.op    = sst_pkg::CELL_REM;
                count_nxt = count_r - CNT_W'(1);
              end else begin
                cmd.op = sst_pkg::CELL_CLR;
              end
            end
            sst_pkg::ACT_MATCH,
            sst_pkg::ACT_KEEP: begin
              cmd.probe = 1'b1;
              if (!in_item.final_req) begin
                cmd.op    = sst_pkg::CELL_MARK;
                tally_nxt = tally_sat;
              end else begin
                out_item_nxt.subset = sub;
                out_item_nxt.equal  = sub && (tally_sat == TAL_W'(count_r));
                if (go_compact) begin
                  cmd.op        = sst_pkg::CELL_MARK;
                  hit_pend_nxt  = hit;
                  out_valid_nxt = 1'b0;
                end else begin
                  cmd.op    = sst_pkg::CELL_CLR;
                  tally_nxt = '0;
                end
              end
            end
            default: begin
            end
          endcase
          out_item_nxt.size = sst_pkg::SIZE_W'(count_nxt);
        end
      end
      sst_pkg::ST_COMPACT: begin
        if (any_unm) begin
          cmd.op    = sst_pkg::CELL_COMPACT;
          count_nxt = count_r - CNT_W'(1);
        end else begin
          cmd.op               = sst_pkg::CELL_CLR;
          tally_nxt            = '0;
          out_valid_nxt        = 1'b1;
          out_item_nxt.hit     = hit_pend_r;
          out_item_nxt.dropped = 1'b0;
          out_item_nxt.size    = sst_pkg::SIZE_W'(count_r);
          out_item_nxt.subset  = 1'b0;
          out_item_nxt.equal   = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    hit_pend_r <= hit_pend_nxt;
    if (!rst_n) begin
      state_r     <= sst_pkg::ST_IDLE;
      count_r     <= '0;
      tally_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      tally_r     <= tally_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire
